// ===== design/utra_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utra_pkg
// Shared constants and the digit encoding for the radix to ASCII converter.
// ---------------------------------------------------------------------------
package utra_pkg;

	localparam int DEFAULT_MAX_DIGITS = 64;
	localparam int DEFAULT_VALUE_BITS = 64;

	localparam int NUMBER_W = 64;
	localparam int RADIX_W  = 6;
	localparam int CHAR_W   = 7;
	localparam int COUNT_W  = 7;

	localparam int DIV_BITS_PER_CYCLE = 4;

	localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
	localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A        = 7'h41;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DECIMAL_LIMIT) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DECIMAL_LIMIT);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/utra_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utra_front
// Accepts conversion requests, trims the value, clamps the radix and queues
// the job for the divider in a two-entry queue.
// ---------------------------------------------------------------------------
module utra_front
	import utra_pkg::*;
#(
	parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic [NUMBER_W-1:0]   number,
	input  wire logic [RADIX_W-1:0]    radix,
	output logic                       job_valid,
	input  wire logic                  job_take,
	output logic [VALUE_BITS-1:0]      job_value,
	output logic [RADIX_W-1:0]         job_radix
);

	logic [VALUE_BITS-1:0] value_q [2];
	logic [RADIX_W-1:0]    radix_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  push;
	logic                  pop;
	logic [RADIX_W-1:0]    radix_clamped;

	always_comb begin
		priority if (radix < RADIX_MIN) begin
			radix_clamped = RADIX_MIN;
		end else if (radix > RADIX_MAX) begin
			radix_clamped = RADIX_MAX;
		end else begin
			radix_clamped = radix;
		end
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign pop        = job_take && job_valid;
	assign job_valid  = (cnt_q != 2'd0);
	assign job_value  = value_q[rd_ptr_q];
	assign job_radix  = radix_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			value_q[wr_ptr_q] <= number[VALUE_BITS-1:0];
			radix_q[wr_ptr_q] <= radix_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/utra_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utra_back
// Repeated division by the radix, four quotient bits a cycle, into a digit
// store, then emission of the digits most significant first as ASCII.
// ---------------------------------------------------------------------------
module utra_back
	import utra_pkg::*;
#(
	parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS,
	parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  job_valid,
	output logic                       job_take,
	input  wire logic [VALUE_BITS-1:0] job_value,
	input  wire logic [RADIX_W-1:0]    job_radix,
	output logic                       digit_valid,
	input  wire logic                  digit_stall,
	output logic [CHAR_W-1:0]          digit_char,
	output logic [COUNT_W-1:0]         digit_count,
	output logic                       last_digit
);

	localparam int DB    = DIV_BITS_PER_CYCLE;
	localparam int QW    = ((VALUE_BITS + DB - 1) / DB) * DB;
	localparam int STEPS = QW / DB;
	localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int IW    = $clog2(MAX_DIGITS);
	localparam int CW    = $clog2(MAX_DIGITS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_RD,
		S_LOAD
	} state_t;

	state_t             state_q;
	logic [QW-1:0]      quot_q;
	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] rem_q;
	logic [SW-1:0]      step_q;
	logic [CW-1:0]      n_q;
	logic [IW-1:0]      rd_idx_q;
	logic [RADIX_W-1:0] rd_data_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_last_q;

	logic [RADIX_W-1:0] store [MAX_DIGITS];

	logic [RADIX_W-1:0] rem_next;
	logic [DB-1:0]      qbits;
	logic [QW-1:0]      quot_next;
	logic               step_last;
	logic               slot_free;
	logic               load_digit;

	always_comb begin
		logic [RADIX_W:0] t;
		logic [RADIX_W-1:0] r;
		r     = rem_q;
		qbits = '0;
		for (int i = 0; i < DB; i++) begin
			t = {r, quot_q[QW-1-i]};
			if (t >= {1'b0, radix_q}) begin
				t = t - {1'b0, radix_q};
				qbits[DB-1-i] = 1'b1;
			end
			r = t[RADIX_W-1:0];
		end
		rem_next  = r;
		quot_next = {quot_q[QW-DB-1:0], qbits};
	end

	assign step_last   = (step_q == SW'(STEPS - 1));
	assign slot_free   = !out_valid_q || !digit_stall;
	assign load_digit  = (state_q == S_LOAD) && slot_free;
	assign job_take    = job_valid && (state_q == S_IDLE);
	assign digit_valid = out_valid_q;
	assign digit_char  = out_char_q;
	assign digit_count = out_count_q;
	assign last_digit  = out_last_q;

	always_ff @(posedge clk) begin
		if (state_q == S_DIV && step_last) begin
			store[n_q[IW-1:0]] <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= store[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			quot_q      <= '0;
			radix_q     <= RADIX_MIN;
			rem_q       <= '0;
			step_q      <= '0;
			n_q         <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_count_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (load_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !digit_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						quot_q  <= QW'(job_value);
						radix_q <= job_radix;
						rem_q   <= '0;
						step_q  <= '0;
						n_q     <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					quot_q <= quot_next;
					if (step_last) begin
						n_q    <= n_q + CW'(1);
						rem_q  <= '0;
						step_q <= '0;
						if (quot_next == '0 || n_q == CW'(MAX_DIGITS - 1)) begin
							rd_idx_q <= n_q[IW-1:0];
							state_q  <= S_RD;
						end
					end else begin
						rem_q  <= rem_next;
						step_q <= step_q + SW'(1);
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (slot_free) begin
						out_char_q  <= digit_to_ascii(rd_data_q);
						out_count_q <= COUNT_W'(n_q);
						out_last_q  <= (rd_idx_q == '0);
						if (rd_idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - IW'(1);
							state_q  <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < radix_q))
		else $error("partial remainder not below radix");

	a_radix_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (radix_q >= RADIX_MIN && radix_q <= RADIX_MAX))
		else $error("radix out of range during conversion");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q <= CW'(MAX_DIGITS)))
		else $error("digit count beyond store depth");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_char_q >= CHAR_ZERO && out_char_q <= 7'h5A
			&& out_count_q != '0))
		else $error("emitted digit malformed");

endmodule

`default_nettype wire

// ===== design/unsigned_to_radix_ascii.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// unsigned_to_radix_ascii
// Converts an unsigned value to ASCII digits in a radix from 2 to 36.
// ---------------------------------------------------------------------------
// Usage: a request (number, radix) is transferred on the item channel when
// item_valid is high and item_stall is low. Each request yields one digit
// transfer per digit on the digit channel, most significant first, with
// digit_count on every transfer and last_digit on the final one. Zero gives
// the single digit '0'. A radix below 2 is taken as 2, above 36 as 36.
// Timing: the divider yields four quotient bits a cycle for each digit; once
// all digits are in the digit store, each is read from the store and then
// loaded into the output register. One item is converted at a time; a
// two-entry request queue takes further requests meanwhile.
// Reset clears the queue, the sequencer and the output register. While the
// receiver stalls, the output digit holds and the sequencer waits.
// ---------------------------------------------------------------------------
module unsigned_to_radix_ascii
	import utra_pkg::*;
#(
	parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS,
	parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire logic [NUMBER_W-1:0] number,
	input  wire logic [RADIX_W-1:0]  radix,
	output logic                     digit_valid,
	input  wire logic                digit_stall,
	output logic [CHAR_W-1:0]        digit_char,
	output logic [COUNT_W-1:0]       digit_count,
	output logic                     last_digit
);

	logic                  job_valid;
	logic                  job_take;
	logic [VALUE_BITS-1:0] job_value;
	logic [RADIX_W-1:0]    job_radix;

	utra_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.number     (number),
		.radix      (radix),
		.job_valid  (job_valid),
		.job_take   (job_take),
		.job_value  (job_value),
		.job_radix  (job_radix)
	);

	utra_back #(
		.MAX_DIGITS(MAX_DIGITS),
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_take    (job_take),
		.job_value   (job_value),
		.job_radix   (job_radix),
		.digit_valid (digit_valid),
		.digit_stall (digit_stall),
		.digit_char  (digit_char),
		.digit_count (digit_count),
		.last_digit  (last_digit)
	);

endmodule

`default_nettype wire
